>>> hdl/ols_pkg.sv
`timescale 1ns / 1ps

package ols_pkg;

   // fixed field widths of the request and response channels
   localparam int TYPE_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // defaults for the top level parameters
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [TYPE_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_REMOVE = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_POS   = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic ins_en;
      logic remove;
   } cell_ctl_type;

endpackage

>>> hdl/ols_cell.sv
`timescale 1ns / 1ps

module ols_cell #(
   parameter int INDEX      = 0,
   parameter int CAPACITY   = ols_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ols_pkg::DATA_WIDTH_DEF,
   parameter int IW         = $clog2(CAPACITY + 1),
   parameter int PW         = (IW > ols_pkg::POS_W) ? IW : ols_pkg::POS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ols_pkg::cell_ctl_type  ctl,
   input  logic [DATA_WIDTH-1:0]  key,
   input  logic [DATA_WIDTH-1:0]  ins_data,
   input  logic [PW-1:0]          pos,
   input  logic [IW-1:0]          count,
   input  logic                   token_in,
   input  logic                   found_in,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic                   token_out,
   output logic                   found_out,
   output logic [DATA_WIDTH-1:0]  data_out
);

   localparam bit HAS_RIGHT = (INDEX < CAPACITY - 1);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  token_ff;
   logic                  found_ff;
   logic                  hit;
   logic                  found_now;

   // compare only while the search token sits here and the slot is occupied
   always_comb begin
      hit       = token_ff && (IW'(INDEX) < count) && (entry_ff == key);
      found_now = found_ff | hit;
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en) begin
         if (pos == PW'(INDEX)) begin
            entry_in = ins_data;
         end else if (pos < PW'(INDEX)) begin
            entry_in = left_data;
         end
      end else if (token_ff && ctl.remove && found_now && HAS_RIGHT) begin
         // close the gap: take the right neighbour before it moves
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
         found_ff <= found_in;
      end
   end

   assign token_out = token_ff;
   assign found_out = found_now;
   assign data_out  = entry_ff;

endmodule

>>> hdl/ordered_list_store.sv
`timescale 1ns / 1ps

// ordered list store: a fixed row of CAPACITY cells holding an ordered list
// request channel (req_valid/req_ready) carries req_type, req_position, req_value
// response channel (rsp_valid/rsp_ready) returns rsp_status and rsp_count
// exactly one response per request transfer, in request order
// append and insert: cells at and above the position shift together, the response
// is valid on the cycle after the transfer; with rsp_ready high one such request
// per cycle; query and remove: a search token walks the cell row one cell per
// cycle, removal closes the gap in the same wave; the response is registered
// when the token reaches the last cell, and no request is taken during the walk
// one request in flight at a time; a new transfer is taken while the
// previous response is being taken in the same cycle
// a stalled response holds in its output register and blocks new requests
// reset empties the list (count to zero) and drops any pending response;
// entry storage itself is not cleared

module ordered_list_store #(
   parameter int CAPACITY   = ols_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ols_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ols_pkg::TYPE_W-1:0]   req_type,
   input  logic [ols_pkg::POS_W-1:0]    req_position,
   input  logic [ols_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ols_pkg::STATUS_W-1:0] rsp_status,
   output logic [ols_pkg::COUNT_W-1:0]  rsp_count
);

   // count width and a position width wide enough for both field and count
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int PW = (IW > ols_pkg::POS_W) ? IW : ols_pkg::POS_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [IW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic                  remove_ff, remove_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ols_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [ols_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                  req_fire;
   ols_pkg::req_kind_type req_kind;
   logic [DATA_WIDTH-1:0] req_key;
   logic [PW-1:0]         cnt_ext;
   logic [PW-1:0]         ins_pos;
   logic                  is_place;
   ols_pkg::status_type   place_status;
   logic                  scan_start;
   logic                  scan_done;
   logic [PW-1:0]         count_wide;
   ols_pkg::cell_ctl_type ctl;

   // cell row links
   logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
   logic                  cell_token [CAPACITY];
   logic                  cell_found [CAPACITY];

   // low DATA_WIDTH bits of the value, zero-extended when the cells are wider
   generate
      if (DATA_WIDTH <= ols_pkg::VALUE_W) begin : g_key_narrow
         assign req_key = req_value[DATA_WIDTH-1:0];
      end else begin : g_key_wide
         assign req_key = {{(DATA_WIDTH - ols_pkg::VALUE_W){1'b0}}, req_value};
      end
   endgenerate

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // append and insert are decided in the transfer cycle
   always_comb begin
      req_kind = ols_pkg::req_kind_type'(req_type);
      cnt_ext  = PW'(count_ff);
      is_place = (req_kind == ols_pkg::REQ_APPEND) || (req_kind == ols_pkg::REQ_INSERT);
      ins_pos  = (req_kind == ols_pkg::REQ_APPEND) ? cnt_ext : PW'(req_position);
      // bad position is checked ahead of full
      if (ins_pos > cnt_ext) begin
         place_status = ols_pkg::STAT_BAD_POS;
      end else if (count_ff == IW'(CAPACITY)) begin
         place_status = ols_pkg::STAT_FULL;
      end else begin
         place_status = ols_pkg::STAT_OK;
      end
      ctl.ins_en = req_fire && is_place && (place_status == ols_pkg::STAT_OK);
      ctl.remove = remove_ff;
      scan_start = req_fire && !is_place;
      // token sitting in the last cell ends the walk
      scan_done  = (state_ff == ST_SCAN) && cell_token[CAPACITY-1];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      remove_in     = remove_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_place) begin
                  if (ctl.ins_en) begin
                     count_in = count_ff + 1'b1;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = place_status;
               end else begin
                  key_in    = req_key;
                  remove_in = (req_kind == ols_pkg::REQ_REMOVE);
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               rsp_valid_in = 1'b1;
               if (cell_found[CAPACITY-1]) begin
                  rsp_status_in = ols_pkg::STAT_OK;
                  if (remove_ff) begin
                     count_in = count_ff - 1'b1;
                  end
               end else begin
                  rsp_status_in = ols_pkg::STAT_NOT_FOUND;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // reported count keeps only the low field bits
      count_wide   = PW'(count_in);
      rsp_count_in = rsp_valid_in && !(rsp_valid_ff && !rsp_ready)
                     ? count_wide[ols_pkg::COUNT_W-1:0] : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      remove_ff     <= remove_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // the cell row: cell 0 takes the token, each cell hands it to the next
   generate
      for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
         logic                  tok_in;
         logic                  fnd_in;
         logic [DATA_WIDTH-1:0] left_d;
         logic [DATA_WIDTH-1:0] right_d;

         if (k == 0) begin : g_head
            assign tok_in = scan_start;
            assign fnd_in = 1'b0;
            assign left_d = '0;
         end else begin : g_body
            assign tok_in = cell_token[k-1];
            assign fnd_in = cell_found[k-1];
            assign left_d = cell_data[k-1];
         end

         if (k == CAPACITY - 1) begin : g_tail
            assign right_d = '0;
         end else begin : g_inner
            assign right_d = cell_data[k+1];
         end

         ols_cell #(
            .INDEX      (k),
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .PW         (PW)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .key        (key_ff),
            .ins_data   (req_key),
            .pos        (ins_pos),
            .count      (count_ff),
            .token_in   (tok_in),
            .found_in   (fnd_in),
            .left_data  (left_d),
            .right_data (right_d),
            .token_out  (cell_token[k]),
            .found_out  (cell_found[k]),
            .data_out   (cell_data[k])
         );
      end
   endgenerate

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule
